// File: rtl/core/cardinal_spline_path_evaluator_defines.svh
// Assertion macros for the cardinal spline path evaluator.
// Used by the top level; expects clk and rst_n in scope.
`ifndef CARDINAL_SPLINE_PATH_EVALUATOR_DEFINES_SVH
`define CARDINAL_SPLINE_PATH_EVALUATOR_DEFINES_SVH

// same-cycle implication
`define CSPE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CSPE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/cspe_pkg.sv
// Shared types and constants for the cardinal spline path evaluator.
// No dependencies.
`default_nettype none
package cspe_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEG,
    ST_FETCH,
    ST_MUL,
    ST_ADD
  } state_t;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_EVAL   = 1'b1;

  localparam logic [2:0] STEP_C2 = 3'd0;
  localparam logic [2:0] STEP_C3 = 3'd1;
  localparam logic [2:0] STEP_C4 = 3'd2;
  localparam logic [2:0] STEP_H1 = 3'd3;
  localparam logic [2:0] STEP_H2 = 3'd4;
  localparam logic [2:0] STEP_H3 = 3'd5;

  localparam int K_W    = 17;
  localparam int FRAC_W = 16;

  localparam logic [15:0] TENSION_RESET = 16'd16384;

  typedef struct packed {
    logic load;
    logic rnd16;
  } mul_ctl_t;

endpackage
`default_nettype wire

// File: rtl/core/cardinal_spline_path_evaluator.sv
// Top level of the cardinal spline path evaluator: point table, sequencer, datapath.
// Depends on cspe_pkg, cspe_mulrnd and cardinal_spline_path_evaluator_defines.svh.
//
// Usage: drive start with in_operation and payload while busy is low; the beat is
// taken on that edge. Append (operation 0) stores in_point_x/y/z at the table end
// and returns a result in the next cycle without raising busy, so appends can
// stream one per cycle. Evaluate (operation 1) raises busy while it forms
// segment and fraction, reads four neighbor points through the single read port
// of the point table, then runs six multiply/round steps per coordinate on the
// one shared multiplier for all three coordinates. The result beat is shown in
// the first cycle with busy low again. An evaluate with an empty table answers
// in the next cycle with status 2, like an append. Each result is shown for one
// cycle with out_valid high; the receiver cannot stall it. Tension is written
// through cfg_valid/cfg_ready (always ready); the user must write it only while
// idle, as the block does not enforce this. Reset (rst_n low, sync) empties the
// table and sets tension to 0.5; table contents are not cleared.
`default_nettype none
`include "cardinal_spline_path_evaluator_defines.svh"
module cardinal_spline_path_evaluator #(
  parameter int MAX_POINTS  = 64,
  parameter int COORD_WIDTH = 32
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                start,
  output logic                               busy,
  input  wire                                in_operation,
  input  wire logic signed [COORD_WIDTH-1:0] in_point_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_point_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_point_z,
  input  wire logic [15:0]                   in_position,
  output logic                               out_valid,
  output logic signed [COORD_WIDTH-1:0]      out_x,
  output logic signed [COORD_WIDTH-1:0]      out_y,
  output logic signed [COORD_WIDTH-1:0]      out_z,
  output logic [1:0]                         out_status,
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [15:0]                   cfg_tension
);
  import cspe_pkg::*;

  localparam int CW     = COORD_WIDTH;
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int ADDR_W = $clog2(MAX_POINTS);
  localparam int IDX_W  = CNT_W + 2;
  localparam int A_W    = CW + 8;
  localparam int S_W    = FRAC_W + CNT_W;
  localparam logic signed [A_W-1:0] SAT_HI = A_W'((64'sd1 <<< (CW - 1)) - 64'sd1);
  localparam logic signed [A_W-1:0] SAT_LO = -SAT_HI - A_W'(1);

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]  cnt_r;
  logic [15:0]       tension_r;
  logic [15:0]       pos_r;
  logic [CNT_W-1:0]  seg_r;
  logic [15:0]       frac_r;
  logic [2:0]        k_r;
  logic [2:0]        step_r;
  logic [1:0]        crd_r;
  logic              out_valid_r;
  logic signed [CW-1:0] out_x_r, out_y_r, out_z_r;
  logic [1:0]        out_status_r;

  logic [3*CW-1:0]   mem [MAX_POINTS];
  logic [3*CW-1:0]   rd_r;
  logic              ok_r;

  logic signed [CW-1:0]  v_r [3][4];
  logic signed [CW-1:0]  res_r [2];
  logic signed [A_W-1:0] c2_r, c3_r, c4_r, acc_r;

  logic                  accept;
  logic                  full;
  logic                  wr_en;
  logic                  mem_rd;
  logic signed [IDX_W-1:0] idx;
  logic                  idx_ok;
  logic [S_W-1:0]        s_prod;
  mul_ctl_t              mul_ctl;
  logic signed [A_W-1:0] mul_a;
  logic [15:0]           mul_k;
  logic signed [A_W-1:0] mul_q;
  logic signed [A_W-1:0] addend;
  logic signed [A_W-1:0] val;
  logic signed [CW-1:0]  sat;
  logic signed [A_W-1:0] e0, e1, e2, e3;

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign full      = (cnt_r == CNT_W'(MAX_POINTS));
  assign wr_en     = accept && (in_operation == OP_APPEND) && !full;

  assign out_valid  = out_valid_r;
  assign out_x      = out_x_r;
  assign out_y      = out_y_r;
  assign out_z      = out_z_r;
  assign out_status = out_status_r;

  assign e0 = A_W'(v_r[0][0]);
  assign e1 = A_W'(v_r[0][1]);
  assign e2 = A_W'(v_r[0][2]);
  assign e3 = A_W'(v_r[0][3]);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && (in_operation == OP_EVAL) && (cnt_r != '0)) state_nxt = ST_SEG;
      end
      ST_SEG:   state_nxt = ST_FETCH;
      ST_FETCH: begin
        if (k_r == 3'd4) state_nxt = ST_MUL;
      end
      ST_MUL:   state_nxt = ST_ADD;
      ST_ADD: begin
        if ((step_r == STEP_H3) && (crd_r == 2'd2)) state_nxt = ST_IDLE;
        else state_nxt = ST_MUL;
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    mem_rd        = (state_r == ST_FETCH) && (k_r != 3'd4);
    mul_ctl.load  = (state_r == ST_MUL);
    mul_ctl.rnd16 = (step_r >= STEP_H1);
  end

  // operand and addend selection
  always_comb begin
    mul_a  = '0;
    mul_k  = tension_r;
    addend = '0;
    unique case (step_r)
      STEP_C2: mul_a = e2 - e0;
      STEP_C3: begin
        mul_a  = (e0 <<< 1) + e1 - (e2 <<< 1) - e3;
        addend = A_W'(3) * (e2 - e1);
      end
      STEP_C4: begin
        mul_a  = e2 + e3 - e0 - e1;
        addend = (e1 - e2) <<< 1;
      end
      STEP_H1: begin
        mul_a  = c4_r;
        mul_k  = frac_r;
        addend = c3_r;
      end
      STEP_H2: begin
        mul_a  = acc_r;
        mul_k  = frac_r;
        addend = c2_r;
      end
      STEP_H3: begin
        mul_a  = acc_r;
        mul_k  = frac_r;
        addend = e1;
      end
      default: mul_a = '0;
    endcase
  end

  cspe_mulrnd #(.A_W(A_W)) u_mul (
    .clk (clk),
    .ctl (mul_ctl),
    .a   (mul_a),
    .k   (mul_k),
    .q   (mul_q)
  );

  always_comb begin
    val = mul_q + addend;
    priority if (val > SAT_HI) sat = CW'(SAT_HI);
    else if (val < SAT_LO)     sat = CW'(SAT_LO);
    else                       sat = CW'(val);
  end

  always_comb begin
    s_prod = S_W'(pos_r) * S_W'(cnt_r);
    idx    = $signed({2'b00, seg_r}) + $signed(IDX_W'(k_r)) - IDX_W'(1);
    idx_ok = !idx[IDX_W-1] && (idx < $signed({2'b00, cnt_r}));
  end

  // point table
  always_ff @(posedge clk) begin
    if (wr_en) mem[cnt_r[ADDR_W-1:0]] <= {in_point_z, in_point_y, in_point_x};
    if (mem_rd) begin
      rd_r <= mem[idx[ADDR_W-1:0]];
      ok_r <= idx_ok;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      tension_r   <= TENSION_RESET;
      out_valid_r <= 1'b0;
      k_r         <= '0;
      step_r      <= STEP_C2;
      crd_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b0;
      if (cfg_valid && cfg_ready) tension_r <= cfg_tension;
      if (wr_en) cnt_r <= cnt_r + CNT_W'(1);
      unique case (state_r)
        ST_IDLE: begin
          if (accept && ((in_operation == OP_APPEND) || (cnt_r == '0))) out_valid_r <= 1'b1;
          k_r    <= '0;
          step_r <= STEP_C2;
          crd_r  <= '0;
        end
        ST_SEG:   k_r <= '0;
        ST_FETCH: k_r <= k_r + 3'd1;
        ST_MUL:   k_r <= k_r;
        ST_ADD: begin
          if (step_r == STEP_H3) begin
            step_r <= STEP_C2;
            crd_r  <= crd_r + 2'd1;
            if (crd_r == 2'd2) out_valid_r <= 1'b1;
          end else begin
            step_r <= step_r + 3'd1;
          end
        end
        default: k_r <= '0;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        pos_r <= in_position;
        if (accept) begin
          out_x_r <= '0;
          out_y_r <= '0;
          out_z_r <= '0;
          if (in_operation == OP_APPEND) out_status_r <= full ? STATUS_FULL : STATUS_OK;
          else out_status_r <= (cnt_r == '0) ? STATUS_EMPTY : STATUS_OK;
        end
      end
      ST_SEG: begin
        seg_r  <= s_prod[S_W-1:FRAC_W];
        frac_r <= s_prod[FRAC_W-1:0];
      end
      ST_FETCH: begin
        if (k_r != 3'd0) begin
          for (int c = 0; c < 3; c++) begin
            v_r[c][0] <= v_r[c][1];
            v_r[c][1] <= v_r[c][2];
            v_r[c][2] <= v_r[c][3];
            v_r[c][3] <= ok_r ? $signed(rd_r[c*CW +: CW]) : '0;
          end
        end
      end
      ST_MUL: begin
        acc_r <= acc_r;
      end
      ST_ADD: begin
        unique case (step_r)
          STEP_C2: c2_r  <= val;
          STEP_C3: c3_r  <= val;
          STEP_C4: c4_r  <= val;
          STEP_H1: acc_r <= val;
          STEP_H2: acc_r <= val;
          STEP_H3: begin
            res_r[0] <= res_r[1];
            res_r[1] <= sat;
            v_r[0]   <= v_r[1];
            v_r[1]   <= v_r[2];
            if (crd_r == 2'd2) begin
              out_x_r <= res_r[0];
              out_y_r <= res_r[1];
              out_z_r <= sat;
            end
          end
          default: acc_r <= acc_r;
        endcase
      end
      default: acc_r <= acc_r;
    endcase
  end

  `CSPE_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_r <= CNT_W'(MAX_POINTS), "point count over capacity")
  `CSPE_ASSERT_IMP(a_status_code, out_valid, (out_status == STATUS_OK) || (out_status == STATUS_FULL) || (out_status == STATUS_EMPTY), "bad status code")
  `CSPE_ASSERT_NXT(a_eval_busy, start && !busy && (in_operation == OP_EVAL) && (cnt_r != '0), busy, "evaluate did not raise busy")
  `CSPE_ASSERT_IMP(a_empty_zero, out_valid && (out_status == STATUS_EMPTY), (out_x == '0) && (out_y == '0) && (out_z == '0), "empty evaluate not zero")

endmodule
`default_nettype wire

// File: rtl/core/cspe_mulrnd.sv
// Shared multiply unit: registered product, then round-half-up shift by 15 or 16.
// Depends on cspe_pkg.
`default_nettype none
module cspe_mulrnd #(
  parameter int A_W = 40
) (
  input  wire                        clk,
  input  cspe_pkg::mul_ctl_t         ctl,
  input  wire logic signed [A_W-1:0] a,
  input  wire logic [15:0]           k,
  output logic signed [A_W-1:0]      q
);
  import cspe_pkg::*;

  localparam int P_W = A_W + K_W;
  localparam logic signed [P_W-1:0] HALF16 = P_W'(32768);
  localparam logic signed [P_W-1:0] HALF15 = P_W'(16384);

  logic signed [P_W-1:0] prod_r;
  logic                  rnd16_r;
  logic signed [P_W-1:0] sum;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      prod_r  <= P_W'(a) * P_W'($signed({1'b0, k}));
      rnd16_r <= ctl.rnd16;
    end
  end

  always_comb begin
    sum = prod_r + (rnd16_r ? HALF16 : HALF15);
    q   = rnd16_r ? A_W'(sum >>> 16) : A_W'(sum >>> 15);
  end

endmodule
`default_nettype wire
